// ===== hdl/ccp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types, codes and constants of the clock control peripheral.
// ----------------------------------------------------------------------------
package ccp_pkg;

    // Field widths
    localparam int ACTION_W   = 4;
    localparam int EV_W       = 6;
    localparam int EV_IDX_W   = 3;
    localparam int SRC_W      = 2;
    localparam int INTERVAL_W = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    // Calibration timer: ticks per interval unit and counter width
    localparam int TICKS_PER_INTERVAL = 8192;
    localparam int INTERVAL_MAX       = (1 << INTERVAL_W) - 1;
    localparam int TIMER_W            = $clog2(INTERVAL_MAX * TICKS_PER_INTERVAL + 1);

    // Request action codes
    localparam logic [ACTION_W-1:0] ACT_TICK       = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_LFSTART    = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_LFSTOP     = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_HFSTART    = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_HFSTOP     = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_CAL        = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_CTSTART    = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_CTSTOP     = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_INTENSET   = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_INTENCLR   = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_EVENTWRITE = 4'd10;

    // Clock state codes
    localparam logic [1:0] CLK_STOPPED  = 2'd0;
    localparam logic [1:0] CLK_STARTING = 2'd1;
    localparam logic [1:0] CLK_STARTED  = 2'd2;
    localparam logic [1:0] CLK_STOPPING = 2'd3;

    // Event and interrupt enable bit positions
    localparam int EV_HFSTARTED = 0;
    localparam int EV_LFSTARTED = 1;
    localparam int EV_DONE      = 2;
    localparam int EV_CTTO      = 3;
    localparam int EV_CTSTARTED = 4;
    localparam int EV_CTSTOPPED = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LF_SOURCE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_INTERVAL = 1'd1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [EV_W-1:0]     enable_mask;
        logic [EV_IDX_W-1:0] event_index;
        logic                event_value;
    } req_t;

    typedef struct packed {
        logic             hf_run_requested;
        logic             hf_running;
        logic             lf_run_requested;
        logic             lf_running;
        logic [SRC_W-1:0] lf_status_source;
        logic [EV_W-1:0]  event_flags;
        logic [EV_W-1:0]  event_pulses;
        logic [EV_W-1:0]  enables;
        logic             irq;
        logic             cal_timer_running;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic                  wr_en;
    } cfg_wr_t;

endpackage

// ===== hdl/ccp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_req_if / ccp_rsp_if
// Valid/ready channels carrying requests into and results out of the block.
// ----------------------------------------------------------------------------
interface ccp_req_if
    import ccp_pkg::*;
    ();

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [EV_W-1:0]     enable_mask;
    logic [EV_IDX_W-1:0] event_index;
    logic                event_value;

    modport source (
        output valid, action, enable_mask, event_index, event_value,
        input  ready
    );

    modport sink (
        input  valid, action, enable_mask, event_index, event_value,
        output ready
    );

endinterface

interface ccp_rsp_if
    import ccp_pkg::*;
    ();

    logic             valid;
    logic             ready;
    logic             hf_run_requested;
    logic             hf_running;
    logic             lf_run_requested;
    logic             lf_running;
    logic [SRC_W-1:0] lf_status_source;
    logic [EV_W-1:0]  event_flags;
    logic [EV_W-1:0]  event_pulses;
    logic [EV_W-1:0]  enables;
    logic             irq;
    logic             cal_timer_running;

    modport source (
        output valid, hf_run_requested, hf_running, lf_run_requested, lf_running,
               lf_status_source, event_flags, event_pulses, enables, irq,
               cal_timer_running,
        input  ready
    );

    modport sink (
        input  valid, hf_run_requested, hf_running, lf_run_requested, lf_running,
               lf_status_source, event_flags, event_pulses, enables, irq,
               cal_timer_running,
        output ready
    );

endinterface

// ===== hdl/ccp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_in_stage
// Input register: captures one request and holds it until the engine
// consumes it; refills in the same cycle it drains.
// ----------------------------------------------------------------------------
module ccp_in_stage
    import ccp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ccp_req_if.sink   req,
    input  logic      advance,
    output logic      item_valid,
    output req_t      item
);

    logic valid_reg;
    logic valid_next;
    req_t item_reg;
    logic take;

    // Accept when empty or draining this cycle
    assign req.ready = !valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.action      <= req.action;
            item_reg.enable_mask <= req.enable_mask;
            item_reg.event_index <= req.event_index;
            item_reg.event_value <= req.event_value;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/ccp_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_engine
// Configuration registers, HF/LF clock state machines, calibration request,
// calibration timer, event flags and interrupt enables. Updates all state
// once per request, when the request advances, and presents the resulting status.
// ----------------------------------------------------------------------------
module ccp_engine
    import ccp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_wr_t cfg,
    input  logic    advance,
    input  req_t    item,
    output rsp_t    result
);

    logic [SRC_W-1:0]      lf_source_reg;
    logic [INTERVAL_W-1:0] cal_interval_reg;

    logic [1:0]         hf_state_reg, hf_state_next;
    logic [1:0]         lf_state_reg, lf_state_next;
    logic               cal_pending_reg, cal_pending_next;
    logic               timer_active_reg, timer_active_next;
    logic [TIMER_W-1:0] timer_remaining_reg, timer_remaining_next;
    logic               hf_req_reg, hf_req_next;
    logic               hf_run_reg, hf_run_next;
    logic               lf_req_reg, lf_req_next;
    logic               lf_run_reg, lf_run_next;
    logic [SRC_W-1:0]   src_reg, src_next;
    logic [EV_W-1:0]    flags_reg, flags_next;
    logic [EV_W-1:0]    enables_reg, enables_next;
    logic [EV_W-1:0]    raised;
    logic [TIMER_W-1:0] timer_load;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lf_source_reg    <= '0;
            cal_interval_reg <= '0;
        end
        else if (cfg.wr_en)
        begin
            case (cfg.index)
                CFG_LF_SOURCE:    lf_source_reg    <= cfg.data[SRC_W-1:0];
                CFG_CAL_INTERVAL: cal_interval_reg <= cfg.data[INTERVAL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Timer reload value: interval in ticks
    assign timer_load = TIMER_W'(cal_interval_reg) * TIMER_W'(TICKS_PER_INTERVAL);

    // Compute next state for the current request
    always_comb
    begin
        hf_state_next        = hf_state_reg;
        lf_state_next        = lf_state_reg;
        cal_pending_next     = cal_pending_reg;
        timer_active_next    = timer_active_reg;
        timer_remaining_next = timer_remaining_reg;
        hf_req_next          = hf_req_reg;
        hf_run_next          = hf_run_reg;
        lf_req_next          = lf_req_reg;
        lf_run_next          = lf_run_reg;
        src_next             = src_reg;
        flags_next           = flags_reg;
        enables_next         = enables_reg;
        raised               = '0;

        case (item.action)
            ACT_TICK:
            begin
                // Complete pending HF transition
                if (hf_state_reg == CLK_STARTING)
                begin
                    hf_state_next        = CLK_STARTED;
                    hf_run_next          = 1'b1;
                    raised[EV_HFSTARTED] = 1'b1;
                end
                else if (hf_state_reg == CLK_STOPPING)
                begin
                    hf_state_next = CLK_STOPPED;
                    hf_run_next   = 1'b0;
                end
                // Complete pending LF transition
                if (lf_state_reg == CLK_STARTING)
                begin
                    lf_state_next        = CLK_STARTED;
                    lf_run_next          = 1'b1;
                    raised[EV_LFSTARTED] = 1'b1;
                end
                else if (lf_state_reg == CLK_STOPPING)
                begin
                    lf_state_next = CLK_STOPPED;
                    lf_run_next   = 1'b0;
                end
                // Finish calibration
                if (cal_pending_reg)
                begin
                    cal_pending_next = 1'b0;
                    raised[EV_DONE]  = 1'b1;
                end
                // Count down the calibration timer
                if (timer_active_reg)
                begin
                    if (timer_remaining_reg <= TIMER_W'(1))
                    begin
                        timer_active_next    = 1'b0;
                        timer_remaining_next = '0;
                        raised[EV_CTTO]      = 1'b1;
                    end
                    else
                    begin
                        timer_remaining_next = timer_remaining_reg - TIMER_W'(1);
                    end
                end
            end
            ACT_LFSTART:
            begin
                src_next      = lf_source_reg;
                lf_req_next   = 1'b1;
                lf_state_next = CLK_STARTING;
            end
            ACT_LFSTOP:
            begin
                if (lf_state_reg inside {CLK_STARTED, CLK_STARTING})
                begin
                    lf_req_next   = 1'b0;
                    lf_state_next = CLK_STOPPING;
                end
            end
            ACT_HFSTART:
            begin
                if (hf_state_reg inside {CLK_STOPPED, CLK_STOPPING})
                begin
                    hf_req_next   = 1'b1;
                    hf_state_next = CLK_STARTING;
                end
            end
            ACT_HFSTOP:
            begin
                if (hf_state_reg inside {CLK_STARTED, CLK_STARTING})
                begin
                    hf_req_next   = 1'b0;
                    hf_state_next = CLK_STOPPING;
                end
            end
            ACT_CAL:
            begin
                cal_pending_next = 1'b1;
            end
            ACT_CTSTART:
            begin
                if (!timer_active_reg)
                begin
                    timer_active_next    = 1'b1;
                    timer_remaining_next = timer_load;
                end
                raised[EV_CTSTARTED] = 1'b1;
            end
            ACT_CTSTOP:
            begin
                timer_active_next    = 1'b0;
                timer_remaining_next = '0;
                raised[EV_CTSTOPPED] = 1'b1;
            end
            ACT_INTENSET:
            begin
                enables_next = enables_reg | item.enable_mask;
            end
            ACT_INTENCLR:
            begin
                enables_next = enables_reg & ~item.enable_mask;
            end
            ACT_EVENTWRITE:
            begin
                // Drop writes to indexes past the last flag
                if (item.event_index < EV_IDX_W'(EV_W))
                begin
                    flags_next[item.event_index] = item.event_value;
                end
            end
            default:
            begin
            end
        endcase

        flags_next = flags_next | raised;
    end

    // Advance state when the request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hf_state_reg        <= CLK_STOPPED;
            lf_state_reg        <= CLK_STOPPED;
            cal_pending_reg     <= 1'b0;
            timer_active_reg    <= 1'b0;
            timer_remaining_reg <= '0;
            hf_req_reg          <= 1'b0;
            hf_run_reg          <= 1'b0;
            lf_req_reg          <= 1'b0;
            lf_run_reg          <= 1'b0;
            src_reg             <= '0;
            flags_reg           <= '0;
            enables_reg         <= '0;
        end
        else if (advance)
        begin
            hf_state_reg        <= hf_state_next;
            lf_state_reg        <= lf_state_next;
            cal_pending_reg     <= cal_pending_next;
            timer_active_reg    <= timer_active_next;
            timer_remaining_reg <= timer_remaining_next;
            hf_req_reg          <= hf_req_next;
            hf_run_reg          <= hf_run_next;
            lf_req_reg          <= lf_req_next;
            lf_run_reg          <= lf_run_next;
            src_reg             <= src_next;
            flags_reg           <= flags_next;
            enables_reg         <= enables_next;
        end
    end

    // Assemble the result from the updated state
    always_comb
    begin
        result.hf_run_requested  = hf_req_next;
        result.hf_running        = hf_run_next;
        result.lf_run_requested  = lf_req_next;
        result.lf_running        = lf_run_next;
        result.lf_status_source  = src_next;
        result.event_flags       = flags_next;
        result.event_pulses      = raised;
        result.enables           = enables_next;
        result.irq               = |(flags_next & enables_next);
        result.cal_timer_running = timer_active_next;
    end

endmodule

// ===== hdl/ccp_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_out_stage
// Result register: holds one result until the consumer takes it and
// reloads in the same cycle it is taken.
// ----------------------------------------------------------------------------
module ccp_out_stage
    import ccp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  rsp_t      result,
    output logic      can_take,
    ccp_rsp_if.source rsp
);

    logic valid_reg;
    logic valid_next;
    rsp_t rsp_reg;

    // Room when empty or being drained
    assign can_take = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp.valid             = valid_reg;
    assign rsp.hf_run_requested  = rsp_reg.hf_run_requested;
    assign rsp.hf_running        = rsp_reg.hf_running;
    assign rsp.lf_run_requested  = rsp_reg.lf_run_requested;
    assign rsp.lf_running        = rsp_reg.lf_running;
    assign rsp.lf_status_source  = rsp_reg.lf_status_source;
    assign rsp.event_flags       = rsp_reg.event_flags;
    assign rsp.event_pulses      = rsp_reg.event_pulses;
    assign rsp.enables           = rsp_reg.enables;
    assign rsp.irq               = rsp_reg.irq;
    assign rsp.cal_timer_running = rsp_reg.cal_timer_running;

endmodule

// ===== hdl/clock_control_peripheral.sv =====
`timescale 1ns / 1ps
// Requests move from the input register to the result register when it has
// room. Throughput: one request per cycle while it has room; the state
// update is a single pass of logic between the input register and the
// result register. Reset: rst_n clears both clocks to stopped, the timer,
// flags, enables, status and configuration registers; the user must not
// present a request during reset, which the block does not enforce.
// ----------------------------------------------------------------------------
// clock_control_peripheral
// HF/LF clock control with calibration, calibration timer, event flags and
// a level interrupt, driven by requests (ticks and commands) and by register writes.
// ----------------------------------------------------------------------------
module clock_control_peripheral
    import ccp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ccp_req_if.sink               req,
    ccp_rsp_if.source             rsp
);

    logic    item_valid;
    req_t    item;
    rsp_t    result;
    logic    can_take;
    logic    advance;
    cfg_wr_t cfg;

    // Move a request forward when the result register has room
    assign advance = item_valid && can_take;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    ccp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ccp_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    ccp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .result   (result),
        .can_take (can_take),
        .rsp      (rsp)
    );

`ifndef SYNTHESIS
    // A request moved forward shows up as a valid result next cycle
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> rsp.valid)
        else $error("result missing after request advanced");

    // Interrupt level matches enabled flags
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.irq == (|(rsp.event_flags & rsp.enables))))
        else $error("irq does not match enabled flags");

    // Raised events are always reflected in the flags
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.event_pulses & ~rsp.event_flags) == '0))
        else $error("event pulse without flag");

    // A timeout leaves the timer stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.event_pulses[EV_CTTO]) |-> !rsp.cal_timer_running)
        else $error("timer still running after timeout");
`endif

endmodule
